// ===== rtl/pfb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pfb_pkg;

	// Display geometry
	localparam int WIDTH  = 128;
	localparam int HEIGHT = 64;
	localparam int PAGES  = 8;

	localparam int COL_W  = $clog2(WIDTH);
	localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int WORD_W = PAGES * 8;

	localparam int QUEUE_DEPTH = 2;

	// Action codes on the request channel
	localparam logic [1:0] ACT_PIXEL = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_FLUSH = 2'd2;

	// Controller command bytes
	localparam logic [7:0] NIBBLE_MASK  = 8'h0F;
	localparam logic [7:0] CMD_COL_HIGH = 8'h10;
	localparam logic [7:0] CMD_PAGE     = 8'hB0;
	localparam logic [7:0] CLEAN_MARK   = 8'hFF;

	localparam logic [3:0] COLUMN_OFFSET_RESET = 4'd2;

	typedef enum logic [1:0] {
		OP_PIXEL = 2'd0,
		OP_CLEAR = 2'd1,
		OP_FLUSH = 2'd2
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [COL_W-1:0]  column;
		logic [PAGE_W-1:0] page;
		logic [2:0]        row;
		logic              erase;
	} pfb_item_t;

	typedef struct packed {
		logic      valid;
		pfb_item_t item;
	} pfb_head_t;

endpackage

`default_nettype wire

// ===== rtl/pfb_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pfb_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [6:0] pixel_x;
	logic [5:0] pixel_y;
	logic       erase;

	modport source (output valid, action, pixel_x, pixel_y, erase, input ready);
	modport sink   (input valid, action, pixel_x, pixel_y, erase, output ready);
endinterface

interface pfb_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_command;
	logic       last_of_refresh;

	modport source (output valid, out_byte, is_command, last_of_refresh, input ready);
	modport sink   (input valid, out_byte, is_command, last_of_refresh, output ready);
endinterface

`default_nettype wire

// ===== rtl/pfb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfb_front import pfb_pkg::*; (
	pfb_req_if.sink   req,
	input  logic      full,
	output logic      push,
	output pfb_item_t item
);

	logic       keep;
	logic       in_range;
	logic [2:0] page_raw;
	op_t        op;

	assign page_raw = req.pixel_y[5:3];

	// Pixels outside the visible area are dropped here and never reach the queue.
	assign in_range = ({1'b0, req.pixel_x} < 8'(WIDTH)) &&
		({1'b0, req.pixel_y} < 7'(HEIGHT)) &&
		({1'b0, page_raw} < 4'(PAGES));

	always_comb begin
		keep = 1'b0;
		op   = OP_FLUSH;
		case (req.action)
			ACT_PIXEL: begin
				keep = in_range;
				op   = OP_PIXEL;
			end
			ACT_CLEAR: begin
				keep = 1'b1;
				op   = OP_CLEAR;
			end
			ACT_FLUSH: begin
				keep = 1'b1;
				op   = OP_FLUSH;
			end
			default: begin
				keep = 1'b0;
				op   = OP_FLUSH;
			end
		endcase
	end

	assign item.op     = op;
	assign item.column = COL_W'(req.pixel_x);
	assign item.page   = PAGE_W'(page_raw);
	assign item.row    = req.pixel_y[2:0];
	assign item.erase  = req.erase;

	assign req.ready = !full;
	assign push      = req.valid && !full && keep;

endmodule

`default_nettype wire

// ===== rtl/pfb_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfb_queue import pfb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  pfb_item_t item,
	output logic      full,
	output pfb_head_t head,
	input  logic      pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	pfb_item_t        entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.item  = entries_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
		logic [PTR_W-1:0] nxt;
		if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
			nxt = '0;
		end else begin
			nxt = ptr + 1'b1;
		end
		return nxt;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= item;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pfb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfb_back import pfb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	input  pfb_head_t  head,
	output logic       pop,
	pfb_rsp_if.source  rsp
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_PIXEL = 3'b010,
		ST_DATA  = 3'b100
	} state_t;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_HIGH = 4'b0010,
		PH_PAGE = 4'b0100,
		PH_DATA = 4'b1000
	} phase_t;

	state_t            state_q;
	phase_t            phase_q;
	logic [3:0]        column_offset_q;
	logic [7:0]        range_lo_q [PAGES];
	logic [7:0]        range_hi_q [PAGES];
	logic [PAGE_W-1:0] flush_page_q;
	logic [7:0]        flush_col_q;
	logic [7:0]        flush_end_q;
	logic [WIDTH-1:0]  col_valid_q;
	pfb_item_t         pix_q;

	// Column-organised store: one word holds the bytes of every page for a column.
	logic [WORD_W-1:0] mem [WIDTH];
	logic [WORD_W-1:0] mem_rdata_q;

	logic              rsp_valid_q;
	logic [7:0]        rsp_byte_q;
	logic              rsp_cmd_q;
	logic              rsp_last_q;

	logic              out_free;
	logic [PAGES-1:0]  page_dirty;
	logic              fd_found;
	logic [PAGE_W-1:0] fd_page;
	logic [7:0]        col_phys;
	logic [7:0]        start_col;
	logic [COL_W-1:0]  rd_col;
	logic [COL_W-1:0]  rd_addr;
	logic [PAGE_W-1:0] sel_page;
	logic [WORD_W-1:0] rd_word;
	logic [7:0]        rd_byte;
	logic [7:0]        bit_mask;
	logic [7:0]        new_byte;
	logic [WORD_W-1:0] new_word;
	logic [7:0]        pix_col8;
	logic              data_last_col;

	logic              do_pixel_rd;
	logic              do_clear;
	logic              do_start;
	logic              do_high;
	logic              do_page;
	logic              do_data_rd;
	logic              do_pixel_wr;
	logic              do_data_emit;
	logic              emit;
	logic [7:0]        emit_byte;
	logic              emit_last;

	assign out_free = !rsp_valid_q || rsp.ready;

	always_comb begin
		for (int p = 0; p < PAGES; p++) begin
			page_dirty[p] = (range_lo_q[p] < 8'(WIDTH)) && (range_hi_q[p] < 8'(WIDTH)) &&
				(range_lo_q[p] <= range_hi_q[p]);
		end
	end

	// Lowest-numbered dirty page wins.
	always_comb begin
		fd_found = 1'b0;
		fd_page  = '0;
		for (int p = PAGES - 1; p >= 0; p--) begin
			if (page_dirty[p]) begin
				fd_found = 1'b1;
				fd_page  = PAGE_W'(p);
			end
		end
	end

	assign col_phys  = flush_col_q + 8'(column_offset_q);
	assign start_col = range_lo_q[fd_page] + 8'(column_offset_q);

	always_comb begin
		do_pixel_rd = 1'b0;
		do_clear    = 1'b0;
		do_start    = 1'b0;
		do_high     = 1'b0;
		do_page     = 1'b0;
		do_data_rd  = 1'b0;
		if (state_q == ST_IDLE && head.valid) begin
			case (head.item.op)
				OP_PIXEL: do_pixel_rd = 1'b1;
				OP_CLEAR: do_clear = 1'b1;
				OP_FLUSH: begin
					if (out_free) begin
						case (phase_q)
							PH_IDLE: do_start   = 1'b1;
							PH_HIGH: do_high    = 1'b1;
							PH_PAGE: do_page    = 1'b1;
							PH_DATA: do_data_rd = 1'b1;
							default: do_start   = 1'b0;
						endcase
					end
				end
				default: do_clear = 1'b0;
			endcase
		end
	end

	assign pop          = do_pixel_rd || do_clear || do_start || do_high || do_page || do_data_rd;
	assign do_pixel_wr  = (state_q == ST_PIXEL);
	assign do_data_emit = (state_q == ST_DATA);

	// Read data of a column that was never written since clear reads as zero.
	assign rd_col   = do_pixel_wr ? pix_q.column : flush_col_q[COL_W-1:0];
	assign sel_page = do_pixel_wr ? pix_q.page : flush_page_q;
	assign rd_word  = col_valid_q[rd_col] ? mem_rdata_q : '0;
	assign rd_byte  = rd_word[sel_page * 8 +: 8];
	assign rd_addr  = do_pixel_rd ? head.item.column : flush_col_q[COL_W-1:0];

	assign bit_mask = 8'd1 << pix_q.row;
	assign new_byte = pix_q.erase ? (rd_byte & ~bit_mask) : (rd_byte | bit_mask);

	always_comb begin
		for (int p = 0; p < PAGES; p++) begin
			if (PAGE_W'(p) == pix_q.page) begin
				new_word[p * 8 +: 8] = new_byte;
			end else begin
				new_word[p * 8 +: 8] = rd_word[p * 8 +: 8];
			end
		end
	end

	assign pix_col8      = 8'(head.item.column);
	assign data_last_col = (flush_col_q >= flush_end_q);

	assign emit = (do_start && fd_found) || do_high || do_page || do_data_emit;

	always_comb begin
		if (do_data_emit) begin
			emit_byte = rd_byte;
		end else if (do_page) begin
			emit_byte = CMD_PAGE | 8'(flush_page_q);
		end else if (do_high) begin
			emit_byte = CMD_COL_HIGH | {4'b0000, col_phys[7:4]};
		end else begin
			emit_byte = start_col & NIBBLE_MASK;
		end
	end

	// The page being sent was already emptied, so this looks at the remaining pages only.
	assign emit_last = do_data_emit && data_last_col && !fd_found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			phase_q         <= PH_IDLE;
			column_offset_q <= COLUMN_OFFSET_RESET;
			flush_page_q    <= '0;
			flush_col_q     <= '0;
			flush_end_q     <= '0;
			col_valid_q     <= '0;
			rsp_valid_q     <= 1'b0;
			for (int p = 0; p < PAGES; p++) begin
				range_lo_q[p] <= CLEAN_MARK;
				range_hi_q[p] <= CLEAN_MARK;
			end
		end else begin
			if (cfg_we) begin
				column_offset_q <= cfg_wdata;
			end

			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			if (do_pixel_rd) begin
				state_q <= ST_PIXEL;
				if (range_lo_q[head.item.page] > pix_col8) begin
					range_lo_q[head.item.page] <= pix_col8;
				end
				if (range_hi_q[head.item.page] < pix_col8 ||
					range_hi_q[head.item.page] >= 8'(WIDTH)) begin
					range_hi_q[head.item.page] <= pix_col8;
				end
			end

			if (do_pixel_wr) begin
				state_q             <= ST_IDLE;
				col_valid_q[rd_col] <= 1'b1;
			end

			if (do_clear) begin
				col_valid_q <= '0;
				for (int p = 0; p < PAGES; p++) begin
					range_lo_q[p] <= '0;
					range_hi_q[p] <= 8'(WIDTH - 1);
				end
			end

			if (do_start && fd_found) begin
				phase_q               <= PH_HIGH;
				flush_page_q          <= fd_page;
				flush_col_q           <= range_lo_q[fd_page];
				flush_end_q           <= range_hi_q[fd_page];
				range_lo_q[fd_page]   <= CLEAN_MARK;
				range_hi_q[fd_page]   <= CLEAN_MARK;
			end

			if (do_high) begin
				phase_q <= PH_PAGE;
			end

			if (do_page) begin
				phase_q <= PH_DATA;
			end

			if (do_data_rd) begin
				state_q <= ST_DATA;
			end

			if (do_data_emit) begin
				state_q <= ST_IDLE;
				if (data_last_col) begin
					phase_q <= PH_IDLE;
				end else begin
					flush_col_q <= flush_col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_pixel_rd) begin
			pix_q <= head.item;
		end
		if (emit) begin
			rsp_byte_q <= emit_byte;
			rsp_cmd_q  <= !do_data_emit;
			rsp_last_q <= emit_last;
		end
	end

	always_ff @(posedge clk) begin
		if (do_pixel_wr) begin
			mem[pix_q.column] <= new_word;
		end
		if (do_pixel_rd || do_data_rd) begin
			mem_rdata_q <= mem[rd_addr];
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.out_byte        = rsp_byte_q;
	assign rsp.is_command      = rsp_cmd_q;
	assign rsp.last_of_refresh = rsp_last_q;

endmodule

`default_nettype wire

// ===== rtl/page_framebuffer_dirty_flush.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload                                   Transfer
// req       in         action, pixel_x, pixel_y, erase           valid && ready
// rsp       out        out_byte, is_command, last_of_refresh     valid && ready
// cfg       in         cfg_wdata (column_offset, 4 bits)         cfg_we
//
// A two-entry queue sits between the request decoder and the executing engine.
// A pixel write is a store read, then a write back; a data byte is a store read,
// then output. Reset leaves the store reading as zero at once through
// per-column valid bits, so there is no clearing pass. A flush transaction
// waits in the queue while the output register holds a byte not yet taken.

module page_framebuffer_dirty_flush import pfb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	pfb_req_if.sink    req,
	pfb_rsp_if.source  rsp
);

	logic      push;
	logic      full;
	logic      pop;
	pfb_item_t item;
	pfb_head_t head;

	pfb_front u_front (
		.req  (req),
		.full (full),
		.push (push),
		.item (item)
	);

	pfb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.full   (full),
		.head   (head),
		.pop    (pop)
	);

	pfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.head      (head),
		.pop       (pop),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
